[rtl/facet_flat_shader_defines.svh]
// Assertion macros for the facet flat shader RTL.
`ifndef FACET_FLAT_SHADER_DEFINES_SVH
`define FACET_FLAT_SHADER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define FFS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("facet_flat_shader check failed");

// Next-cycle implication, clocked on clk, off during rst.
`define FFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("facet_flat_shader check failed");

`endif

[rtl/ffs_pkg.sv]
// Types and constants of the facet flat shader.
package ffs_pkg;

  localparam int COORD_W   = 32;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int EMAG_W    = COORD_W;
  localparam int ESH_W     = 31;
  localparam int PROD_W    = 2 * ESH_W;
  localparam int CROSS_W   = PROD_W;
  localparam int CMAG_W    = CROSS_W - 1;
  localparam int NRM_W     = 30;
  localparam int NRM_TOP   = NRM_W - 1;
  localparam int SQR_W     = 2 * NRM_W;
  localparam int SUM_W     = SQR_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int SQ_REM_W  = ROOT_W + 1;
  localparam int SQ_LAT    = ROOT_W;
  localparam int Q_W       = 15;
  localparam int DIV_LAT   = Q_W;
  localparam int FRONT_LAT = 11;
  localparam int NOUT_W    = 16;
  localparam int CAM_W     = 16;
  localparam int DOT_W     = 32;
  localparam int DOT_FRAC  = 28;
  localparam int CH_W      = 8;
  localparam int MUL_W     = DOT_W + CH_W;
  localparam int COLOR_W   = 3 * CH_W;
  localparam int CNT_W     = 8;
  localparam int IN_W      = 9 * COORD_W + CNT_W + COLOR_W;
  localparam int OUT_W     = 80;

  // -1.0 in the Q3.28 dot format
  localparam logic signed [DOT_W-1:0] DOT_NEG_ONE = -(DOT_W'(1) << DOT_FRAC);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_CAM_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CAM_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CAM_Z = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DSIDE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WIRE  = 3'd4;
  localparam logic signed [CAM_W-1:0] CAM_Z_RESET = 16'sd16384;

  localparam logic [1:0] MODE_POLY = 2'd0;
  localparam logic [1:0] MODE_TRI  = 2'd1;
  localparam logic [1:0] MODE_LINE = 2'd2;
  localparam logic [1:0] MODE_LOOP = 2'd3;

  localparam logic [CNT_W-1:0] CNT_TWO   = 8'd2;
  localparam logic [CNT_W-1:0] CNT_THREE = 8'd3;

  typedef struct packed {
    logic               zero;
    logic               two_pt;
    logic [1:0]         mode;
    logic [COLOR_W-1:0] color;
    logic [2:0]         neg;
  } side_t;

  typedef struct packed {
    side_t                     side;
    logic [2:0][NRM_W-1:0]     cm;
  } line_t;

endpackage

[rtl/ffs_front.sv]
// Edge vectors, cross product, normalisation and sum of squares.
module ffs_front import ffs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ce,
  input  logic                     in_valid,
  input  logic [2:0][COORD_W-1:0]  pa,
  input  logic [2:0][COORD_W-1:0]  pb,
  input  logic [2:0][COORD_W-1:0]  pc,
  input  side_t                    in_side,
  output logic                     out_valid,
  output side_t                    out_side,
  output logic [2:0][NRM_W-1:0]    out_cm,
  output logic [SUM_W-1:0]         out_sum
);

  localparam int ST_SIGN = 5;
  localparam int ST_PICK = 7;

  logic [FRONT_LAT-1:0] vld;
  side_t                sd [FRONT_LAT];

  logic signed [EDGE_W-1:0]  edg  [6];
  logic [EMAG_W-1:0]         emag [6];
  logic                      eneg [6];
  logic signed [ESH_W-1:0]   esh  [6];
  logic signed [PROD_W-1:0]  prd  [6];
  logic signed [CROSS_W-1:0] crs  [3];
  logic [CMAG_W-1:0]         cm6  [3];
  logic [CMAG_W-1:0]         cm7  [3];
  logic [7:0]                gany;
  logic [2:0]                gpos [8];
  logic [CMAG_W-1:0]         cm8  [3];
  logic                      rsh;
  logic [4:0]                amt;
  logic [NRM_W-1:0]          cm9  [3];
  logic [NRM_W-1:0]          cm10 [3];
  logic [SQR_W-1:0]          sqr  [3];
  logic [NRM_W-1:0]          cm11 [3];
  logic [SUM_W-1:0]          sum;

  // Edge shift: 2 if any magnitude reaches 2^31, 1 if 2^30
  logic                      sh2, sh1;
  logic [63:0]               orv;
  logic [7:0]                gany_c;
  logic [2:0]                gpos_c [8];
  logic [5:0]                lead;

  // side data picking up the cross product signs and the zero flag
  side_t                     sd_sign, sd_pick;

  always_comb begin
    sh2 = 1'b0;
    sh1 = 1'b0;
    for (int i = 0; i < 6; i++) begin
      sh2 = sh2 | emag[i][EMAG_W-1];
      sh1 = sh1 | emag[i][EMAG_W-2];
    end
  end

  always_comb begin
    orv = {3'b000, cm7[0] | cm7[1] | cm7[2]};
    orv[CMAG_W-1:0] = cm6[0] | cm6[1] | cm6[2];
    for (int g = 0; g < 8; g++) begin
      gany_c[g] = |orv[g*8 +: 8];
      gpos_c[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (orv[g*8 + b]) gpos_c[g] = 3'(b);
      end
    end
  end

  always_comb begin
    lead = 6'd0;
    for (int g = 0; g < 8; g++) begin
      if (gany[g]) lead = {3'(g), gpos[g]};
    end
  end

  always_comb begin
    sd_sign      = sd[ST_SIGN-1];
    sd_sign.neg  = {crs[2][CROSS_W-1], crs[1][CROSS_W-1], crs[0][CROSS_W-1]};
    sd_pick      = sd[ST_PICK-1];
    sd_pick.zero = sd[ST_PICK-1].zero | ~(|gany);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[FRONT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sd[0] <= in_side;
      for (int k = 1; k < FRONT_LAT; k++) begin
        if (k == ST_SIGN)      sd[k] <= sd_sign;
        else if (k == ST_PICK) sd[k] <= sd_pick;
        else                   sd[k] <= sd[k-1];
      end

      // F1: edges from the first vertex
      for (int i = 0; i < 3; i++) begin
        edg[i]   <= $signed({pb[i][COORD_W-1], pb[i]}) - $signed({pa[i][COORD_W-1], pa[i]});
        edg[i+3] <= $signed({pc[i][COORD_W-1], pc[i]}) - $signed({pa[i][COORD_W-1], pa[i]});
      end
      // F2: magnitudes
      for (int i = 0; i < 6; i++) begin
        eneg[i] <= edg[i][EDGE_W-1];
        emag[i] <= edg[i][EDGE_W-1] ? EMAG_W'(-edg[i]) : EMAG_W'(edg[i]);
      end
      // F3: common right shift, sign restored (truncates toward zero)
      for (int i = 0; i < 6; i++) begin
        if (sh2)
          esh[i] <= eneg[i] ? -$signed({1'b0, emag[i][EMAG_W-1:2]})
                            :  $signed({1'b0, emag[i][EMAG_W-1:2]});
        else if (sh1)
          esh[i] <= eneg[i] ? -$signed({1'b0, emag[i][EMAG_W-2:1]})
                            :  $signed({1'b0, emag[i][EMAG_W-2:1]});
        else
          esh[i] <= eneg[i] ? -$signed({1'b0, emag[i][EMAG_W-3:0]})
                            :  $signed({1'b0, emag[i][EMAG_W-3:0]});
      end
      // F4: six partial products of the cross product
      prd[0] <= esh[1] * esh[5];
      prd[1] <= esh[2] * esh[4];
      prd[2] <= esh[2] * esh[3];
      prd[3] <= esh[0] * esh[5];
      prd[4] <= esh[0] * esh[4];
      prd[5] <= esh[1] * esh[3];
      // F5: cross product
      crs[0] <= prd[0] - prd[1];
      crs[1] <= prd[2] - prd[3];
      crs[2] <= prd[4] - prd[5];
      // F6: magnitudes
      for (int i = 0; i < 3; i++)
        cm6[i] <= crs[i][CROSS_W-1] ? CMAG_W'(-crs[i]) : CMAG_W'(crs[i]);
      // F7: leading one per byte
      gany <= gany_c;
      for (int g = 0; g < 8; g++) gpos[g] <= gpos_c[g];
      cm7 <= cm6;
      // F8: shift so the largest lands in [2^29, 2^30)
      rsh <= (lead >= 6'(NRM_TOP));
      amt <= (lead >= 6'(NRM_TOP)) ? 5'(lead - 6'(NRM_TOP)) : 5'(6'(NRM_TOP) - lead);
      cm8 <= cm7;
      // F9
      for (int i = 0; i < 3; i++)
        cm9[i] <= rsh ? NRM_W'(cm8[i] >> amt) : NRM_W'(cm8[i] << amt);
      // F10
      for (int i = 0; i < 3; i++)
        sqr[i] <= SQR_W'(cm9[i]) * SQR_W'(cm9[i]);
      cm10 <= cm9;
      // F11
      sum  <= SUM_W'(sqr[0]) + SUM_W'(sqr[1]) + SUM_W'(sqr[2]);
      cm11 <= cm10;
    end
  end

  assign out_valid = vld[FRONT_LAT-1];
  assign out_side  = sd[FRONT_LAT-1];
  assign out_sum   = sum;
  assign out_cm    = {cm11[2], cm11[1], cm11[0]};

endmodule

[rtl/ffs_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module ffs_sqrt import ffs_pkg::*; (
  input  logic              clk,
  input  logic              ce,
  input  logic [SUM_W-1:0]  x,
  output logic [ROOT_W-1:0] root
);

  logic [SUM_W-1:0]    xr   [SQ_LAT+1];
  logic [SQ_REM_W-1:0] rem  [SQ_LAT+1];
  logic [ROOT_W-1:0]   rt   [SQ_LAT+1];

  assign xr[0]  = x;
  assign rem[0] = '0;
  assign rt[0]  = '0;

  for (genvar k = 0; k < SQ_LAT; k++) begin : g_stage
    logic [SQ_REM_W+1:0] cur, trial;
    always_comb begin
      cur   = {rem[k], xr[k][SUM_W-1 -: 2]};
      trial = {1'b0, rt[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        xr[k+1] <= xr[k] << 2;
        if (cur >= trial) begin
          rem[k+1] <= SQ_REM_W'(cur - trial);
          rt[k+1]  <= {rt[k][ROOT_W-2:0], 1'b1};
        end else begin
          rem[k+1] <= SQ_REM_W'(cur);
          rt[k+1]  <= {rt[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt[SQ_LAT];

endmodule

[rtl/ffs_div.sv]
// Pipelined restoring divider: floor(cm * 2^14 / d), one bit per stage.
module ffs_div import ffs_pkg::*; (
  input  logic              clk,
  input  logic              ce,
  input  logic [NRM_W-1:0]  cm,
  input  logic [ROOT_W-1:0] d,
  output logic [Q_W-1:0]    q
);

  logic [ROOT_W-1:0] rem [DIV_LAT+1];
  logic [ROOT_W-1:0] dd  [DIV_LAT+1];
  logic [Q_W-1:0]    qq  [DIV_LAT+1];

  // cm * 2^14 >> 15 is below d, so the first remainder is cm >> 1
  assign rem[0] = ROOT_W'(cm[NRM_W-1:1]);
  assign dd[0]  = d;
  assign qq[0]  = '0;

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic             nb;
    logic [ROOT_W:0]  cur;
    if (k == 0) begin : g_lsb
      assign nb = cm[0];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign cur = {rem[k], nb};
    always_ff @(posedge clk) begin
      if (ce) begin
        dd[k+1] <= dd[k];
        if (cur >= {1'b0, dd[k]}) begin
          rem[k+1] <= ROOT_W'(cur - {1'b0, dd[k]});
          qq[k+1]  <= {qq[k][Q_W-2:0], 1'b1};
        end else begin
          rem[k+1] <= ROOT_W'(cur);
          qq[k+1]  <= {qq[k][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign q = qq[DIV_LAT];

endmodule

[rtl/facet_flat_shader.sv]
// Top level of the facet flat shader: config, pipeline, shading and output buffer.
//
// Flat Lambert shading with back-face cull, one facet per transfer.
// s_tdata carries the first three vertices (Q16.16), the vertex count and the
// base colour; m_tdata returns the Q1.14 unit normal, the shaded RGB and the
// draw mode. Exactly one result leaves for every facet taken, in order.
// Throughput: one facet per cycle while the receiver keeps up.
// Pipeline: 11 front stages, 31 square-root stages, 15 divider stages,
// 4 shading stages and the output register, from input transfer to m_tvalid.
// The depth is set by the bit-serial square root and divider pipelines.
// Config: cfg_we writes cfg_wdata to register cfg_addr (camera x, y, z in
// Q1.14, double_sided, wireframe); write only while the pipeline is empty.
// Reset: rst clears all valid bits and restores the register defaults
// (camera along +z, single sided, no wireframe).
// Stall: a held m_tvalid diverts the next result into a one-entry skid
// register; only once that fills does s_tready drop and the whole pipeline
// freeze, so nothing is lost or repeated.
`include "facet_flat_shader_defines.svh"

module facet_flat_shader import ffs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // facet in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, point_count, base_color
  input  logic [IN_W-1:0]       s_tdata,
  // shaded facet out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // norm_x, norm_y, norm_z, shade_red, shade_green, shade_blue, draw_mode, pad
  output logic [OUT_W-1:0]      m_tdata
);

  // configuration
  logic signed [CAM_W-1:0] cam [3];
  logic                    double_sided;
  logic                    wireframe;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam[0]       <= '0;
      cam[1]       <= '0;
      cam[2]       <= CAM_Z_RESET;
      double_sided <= 1'b0;
      wireframe    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CAM_X: cam[0]       <= $signed(cfg_wdata);
        REG_CAM_Y: cam[1]       <= $signed(cfg_wdata);
        REG_CAM_Z: cam[2]       <= $signed(cfg_wdata);
        REG_DSIDE: double_sided <= cfg_wdata[0];
        REG_WIRE:  wireframe    <= cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  // global advance: the pipeline only freezes once the skid is occupied
  logic ce;
  logic skid_valid;
  logic [OUT_W-1:0] skid_data;

  assign ce       = ~skid_valid;
  assign s_tready = ce;

  // unpack input transfer
  logic [2:0][COORD_W-1:0] pa, pb, pc;
  logic [CNT_W-1:0]        cnt;
  side_t                   in_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i] = s_tdata[i*COORD_W +: COORD_W];
      pb[i] = s_tdata[(i+3)*COORD_W +: COORD_W];
      pc[i] = s_tdata[(i+6)*COORD_W +: COORD_W];
    end
    cnt            = s_tdata[9*COORD_W +: CNT_W];
    in_side.color  = s_tdata[9*COORD_W + CNT_W +: COLOR_W];
    in_side.zero   = (cnt < CNT_THREE);
    in_side.two_pt = (cnt == CNT_TWO);
    in_side.neg    = '0;
    if (wireframe) begin
      in_side.mode = MODE_LOOP;
    end else begin
      case (cnt)
        CNT_THREE: in_side.mode = MODE_TRI;
        CNT_TWO:   in_side.mode = MODE_LINE;
        default:   in_side.mode = MODE_POLY;
      endcase
    end
  end

  // front: edges through sum of squares
  logic                  f_valid;
  side_t                 f_side;
  logic [2:0][NRM_W-1:0] f_cm;
  logic [SUM_W-1:0]      f_sum;

  ffs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .pa        (pa),
    .pb        (pb),
    .pc        (pc),
    .in_side   (in_side),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_cm    (f_cm),
    .out_sum   (f_sum)
  );

  // length = floor(sqrt(sum)); item data waits alongside
  logic [ROOT_W-1:0] len;

  ffs_sqrt u_sqrt (
    .clk  (clk),
    .ce   (ce),
    .x    (f_sum),
    .root (len)
  );

  logic [SQ_LAT-1:0] a_vld;
  line_t             a_ln [SQ_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= '0;
    end else if (ce) begin
      a_vld <= {a_vld[SQ_LAT-2:0], f_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_ln[0] <= '{side: f_side, cm: f_cm};
      for (int k = 1; k < SQ_LAT; k++) a_ln[k] <= a_ln[k-1];
    end
  end

  // three divider lanes: component * 16384 / length
  logic [Q_W-1:0] q [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ffs_div u_div (
      .clk (clk),
      .ce  (ce),
      .cm  (a_ln[SQ_LAT-1].cm[i]),
      .d   (len),
      .q   (q[i])
    );
  end

  logic [DIV_LAT-1:0] b_vld;
  side_t              b_sd [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= '0;
    end else if (ce) begin
      b_vld <= {b_vld[DIV_LAT-2:0], a_vld[SQ_LAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      b_sd[0] <= a_ln[SQ_LAT-1].side;
      for (int k = 1; k < DIV_LAT; k++) b_sd[k] <= b_sd[k-1];
    end
  end

  // shading stages P1..P4
  logic [3:0]               p_vld;
  side_t                    p1_sd, p2_sd, p3_sd, p4_sd;
  logic signed [NOUT_W-1:0] n1 [3];
  logic signed [NOUT_W-1:0] n2 [3];
  logic signed [NOUT_W-1:0] n3 [3];
  logic signed [NOUT_W-1:0] n4 [3];
  logic signed [DOT_W-1:0]  prj [3];
  logic signed [DOT_W-1:0]  dot;
  logic [DOT_W-1:0]         fac;
  logic [COLOR_W-1:0]       col3;
  logic [MUL_W-1:0]         mul [3];

  always_comb begin
    dot = prj[0] + prj[1] + prj[2];
    if (p2_sd.two_pt) dot = DOT_NEG_ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= '0;
    end else if (ce) begin
      p_vld <= {p_vld[2:0], b_vld[DIV_LAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // P1: signed normal, zero for short or degenerate facets
      p1_sd <= b_sd[DIV_LAT-1];
      for (int i = 0; i < 3; i++) begin
        if (b_sd[DIV_LAT-1].zero)
          n1[i] <= '0;
        else if (b_sd[DIV_LAT-1].neg[i])
          n1[i] <= -$signed(NOUT_W'(q[i]));
        else
          n1[i] <= $signed(NOUT_W'(q[i]));
      end
      // P2: projections on the camera direction
      p2_sd <= p1_sd;
      n2    <= n1;
      for (int i = 0; i < 3; i++) prj[i] <= n1[i] * cam[i];
      // P3: factor, cull
      p3_sd <= p2_sd;
      n3    <= n2;
      fac   <= dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
      col3  <= (dot > 0 && !double_sided) ? '0 : p2_sd.color;
      // P4: channel scaling
      p4_sd <= p3_sd;
      n4    <= n3;
      for (int i = 0; i < 3; i++)
        mul[i] <= MUL_W'(fac) * MUL_W'(col3[(2-i)*CH_W +: CH_W]);
    end
  end

  // result word: truncate by 2^28 and saturate at 255
  logic [OUT_W-1:0] res;
  logic [CH_W-1:0]  ch [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (|mul[i][MUL_W-1:DOT_FRAC+CH_W])
        ch[i] = '1;
      else
        ch[i] = mul[i][DOT_FRAC +: CH_W];
    end
    res = {6'b0, p4_sd.mode, ch[2], ch[1], ch[0], n4[2], n4[1], n4[0]};
  end

  // output register with one-entry skid
  logic push, take;

  assign push = ce & p_vld[3];
  assign take = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        m_tdata    <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (!m_tvalid || take) begin
      m_tvalid <= push;
      if (push) m_tdata <= res;
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= res;
    end
  end

  // skid only fills behind a held output
  `FFS_ASSERT_IMPL(a_skid_behind_out, skid_valid, m_tvalid)
  // a stalled skid keeps both entries
  `FFS_ASSERT_NEXT(a_skid_holds, skid_valid && !m_tready, skid_valid && m_tvalid)
  // zeroed facets leave P1 with a zero normal
  `FFS_ASSERT_IMPL(a_zero_normal, p_vld[0] && p1_sd.zero,
                   n1[0] == '0 && n1[1] == '0 && n1[2] == '0)

endmodule
